// ----- rtl/etfp_pkg.sv -----
// ----------------------------------------------------------------------------
// etfp_pkg: shared types and constants for the escape-time fractal pixel
// Word formats, datapath command codes, register indexes and the colour
// palette.
// ----------------------------------------------------------------------------
package etfp_pkg;

	localparam int FRAC_BITS      = 28;
	localparam int MAX_ITERATIONS = 255;

	localparam int COORD_W  = 32;   // config registers and c
	localparam int COLUMN_W = 10;
	localparam int ROW_W    = 9;
	localparam int COUNT_W  = 8;
	localparam int CHAN_W   = 8;
	localparam int POS_W    = 33;   // real part after its update
	localparam int IMAG_W   = 34;   // imaginary part after its update
	localparam int SQ_W     = 37;   // x2, y2 as held between iterations
	localparam int OPND_W   = 34;   // shared multiplier operand
	localparam int PROD_W   = 2 * OPND_W;
	localparam int SUM_W    = COORD_W + 12;  // start + index * step
	localparam int CFG_INDEX_W = 2;
	localparam int PAL_IDX_W   = 4;

	localparam logic [SQ_W:0] ESCAPE_LIMIT = (SQ_W + 1)'(64'd4 << FRAC_BITS);
	localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(MAX_ITERATIONS);
	localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(MAX_ITERATIONS - 1);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_X_START = 2'd0,
		REG_X_STEP  = 2'd1,
		REG_Y_START = 2'd2,
		REG_Y_STEP  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [COLUMN_W-1:0] column;
		logic [ROW_W-1:0]    row;
	} pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic [COUNT_W-1:0] iteration_count;
	} result_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} colour_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_CX,
		OP_CY,
		OP_INIT,
		OP_MUL,
		OP_SQX,
		OP_SQY
	} dp_op_t;

	typedef struct packed {
		dp_op_t             op;
		logic               capture;
		logic               load_out;
		logic [COUNT_W-1:0] count;
	} dp_cmd_t;

	typedef struct packed {
		logic escaped;
	} dp_status_t;

	function automatic colour_t palette_lookup(input logic [PAL_IDX_W-1:0] idx);
		colour_t c;
		case (idx)
			4'd0:    c = {8'd9,   8'd1,   8'd47};
			4'd1:    c = {8'd4,   8'd4,   8'd73};
			4'd2:    c = {8'd0,   8'd7,   8'd100};
			4'd3:    c = {8'd12,  8'd44,  8'd138};
			4'd4:    c = {8'd24,  8'd82,  8'd177};
			4'd5:    c = {8'd57,  8'd125, 8'd209};
			4'd6:    c = {8'd134, 8'd181, 8'd229};
			4'd7:    c = {8'd211, 8'd236, 8'd248};
			4'd8:    c = {8'd241, 8'd233, 8'd191};
			4'd9:    c = {8'd248, 8'd201, 8'd95};
			4'd10:   c = {8'd255, 8'd170, 8'd0};
			4'd11:   c = {8'd204, 8'd128, 8'd0};
			4'd12:   c = {8'd153, 8'd87,  8'd0};
			4'd13:   c = {8'd106, 8'd52,  8'd3};
			4'd14:   c = {8'd66,  8'd30,  8'd15};
			4'd15:   c = {8'd25,  8'd7,   8'd26};
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/etfp_datapath.sv -----
// ----------------------------------------------------------------------------
// etfp_datapath: coordinate and iteration datapath
// Holds the config registers, forms c, runs z = z^2 + c through one shared
// signed multiplier and holds the result word.
// ----------------------------------------------------------------------------
module etfp_datapath import etfp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]     cfg_data,
	input  pixel_t                 pixel_data,
	input  dp_cmd_t                cmd,
	output dp_status_t             status,
	output result_t                result_data
);

	logic [COORD_W-1:0] x_start_q, x_step_q, y_start_q, y_step_q;

	logic [COLUMN_W-1:0] column_q;
	logic [ROW_W-1:0]    row_q;
	logic [COORD_W-1:0]  cx_q, cy_q;
	logic [PROD_W-1:0]   prod_q;
	logic [POS_W-1:0]    x_q;
	logic [IMAG_W-1:0]   y_q;
	logic [SQ_W-1:0]     x2_q, y2_q;
	result_t             result_q;

	logic signed [OPND_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic [SUM_W-1:0]  coord_start, coord_sum;
	logic [IMAG_W-1:0] y_next;
	logic [SQ_W:0]     x_diff, mag_sum;
	logic [SQ_W-1:0]   sq_next;
	colour_t           colour;

	function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] v);
		logic [SUM_W-COORD_W:0] top;
		top = v[SUM_W-1:COORD_W-1];
		if ((&top) || !(|top))
			return v[COORD_W-1:0];
		else if (v[SUM_W-1])
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q <= '0;
			x_step_q  <= '0;
			y_start_q <= '0;
			y_step_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_X_START: x_start_q <= cfg_data;
				REG_X_STEP:  x_step_q  <= cfg_data;
				REG_Y_START: y_start_q <= cfg_data;
				REG_Y_STEP:  y_step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared multiplier: index * step, 2xy, x*x, y*y
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_CX: begin
				mul_a = {{(OPND_W-COLUMN_W){1'b0}}, column_q};
				mul_b = {{(OPND_W-COORD_W){x_step_q[COORD_W-1]}}, x_step_q};
			end
			OP_CY: begin
				mul_a = {{(OPND_W-ROW_W){1'b0}}, row_q};
				mul_b = {{(OPND_W-COORD_W){y_step_q[COORD_W-1]}}, y_step_q};
			end
			OP_MUL: begin
				mul_a = {x_q, 1'b0};
				mul_b = y_q;
			end
			OP_SQX: begin
				mul_a = {{(OPND_W-POS_W){x_q[POS_W-1]}}, x_q};
				mul_b = {{(OPND_W-POS_W){x_q[POS_W-1]}}, x_q};
			end
			OP_SQY: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// start value for whichever coordinate the product in prod_q belongs to
	assign coord_start = (cmd.op == OP_CY)
		? {{(SUM_W-COORD_W){x_start_q[COORD_W-1]}}, x_start_q}
		: {{(SUM_W-COORD_W){y_start_q[COORD_W-1]}}, y_start_q};
	assign coord_sum = coord_start + prod_q[SUM_W-1:0];

	// floor(2xy / 2^F) is an arithmetic shift of the signed product
	assign y_next = prod_q[FRAC_BITS+IMAG_W-1:FRAC_BITS]
		+ {{(IMAG_W-COORD_W){cy_q[COORD_W-1]}}, cy_q};
	assign x_diff = {1'b0, x2_q} - {1'b0, y2_q}
		+ {{(SQ_W+1-COORD_W){cx_q[COORD_W-1]}}, cx_q};
	assign sq_next = mul_p[FRAC_BITS+SQ_W-1:FRAC_BITS];
	assign mag_sum = {1'b0, x2_q} + {1'b0, y2_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			column_q <= pixel_data.column;
			row_q    <= pixel_data.row;
		end
		case (cmd.op)
			OP_CX: prod_q <= mul_p;
			OP_CY: begin
				prod_q <= mul_p;
				cx_q   <= sat_coord(coord_sum);
			end
			OP_INIT: begin
				cy_q <= sat_coord(coord_sum);
				x_q  <= '0;
				y_q  <= '0;
				x2_q <= '0;
				y2_q <= '0;
			end
			OP_MUL: begin
				prod_q <= mul_p;
				x_q    <= x_diff[POS_W-1:0];
			end
			OP_SQX: begin
				y_q  <= y_next;
				x2_q <= sq_next;
			end
			OP_SQY: y2_q <= sq_next;
			default: ;
		endcase
		if (cmd.load_out)
			result_q <= {colour, cmd.count};
	end

	assign colour = (cmd.count == COUNT_MAX) ? '0 : palette_lookup(cmd.count[PAL_IDX_W-1:0]);

	assign status.escaped = (mag_sum > ESCAPE_LIMIT);
	assign result_data    = result_q;

endmodule

// ----- rtl/etfp_ctrl.sv -----
// ----------------------------------------------------------------------------
// etfp_ctrl: sequencer for the escape-time fractal pixel
// Steps the datapath through coordinate set-up and the three-phase
// iteration, counts iterations and owns the result word's valid.
// ----------------------------------------------------------------------------
module etfp_ctrl import etfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_valid,
	output logic       pixel_ready,
	output logic       result_valid,
	input  logic       result_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_CX   = 8'b0000_0010,
		S_CY   = 8'b0000_0100,
		S_INIT = 8'b0000_1000,
		S_MUL  = 8'b0001_0000,
		S_SQX  = 8'b0010_0000,
		S_SQY  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t             state_q, state_d;
	logic [COUNT_W-1:0] it_q, count_q, fin_count;
	logic               pend_q;   // an iteration has completed since set-up
	logic               result_valid_q;
	logic               finish, step;

	always_comb begin
		state_d     = state_q;
		cmd.op      = OP_HOLD;
		cmd.capture = 1'b0;
		cmd.load_out = 1'b0;
		cmd.count   = count_q;
		finish      = 1'b0;
		fin_count   = count_q;
		step        = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.capture = pixel_valid;
				if (pixel_valid)
					state_d = S_CX;
			end
			S_CX: begin
				cmd.op  = OP_CX;
				state_d = S_CY;
			end
			S_CY: begin
				cmd.op  = OP_CY;
				state_d = S_INIT;
			end
			S_INIT: begin
				cmd.op  = OP_INIT;
				state_d = S_MUL;
			end
			S_MUL: begin
				// op kept off the escape test; a finished pixel just drops the product
				cmd.op = OP_MUL;
				// escape test on the iteration just finished
				if (pend_q && status.escaped) begin
					finish    = 1'b1;
					fin_count = it_q;
					state_d   = S_DONE;
				end else if (pend_q && it_q == COUNT_LAST) begin
					finish    = 1'b1;
					fin_count = COUNT_MAX;
					state_d   = S_DONE;
				end else begin
					step    = pend_q;
					state_d = S_SQX;
				end
			end
			S_SQX: begin
				cmd.op  = OP_SQX;
				state_d = S_SQY;
			end
			S_SQY: begin
				cmd.op  = OP_SQY;
				state_d = S_MUL;
			end
			S_DONE: begin
				if (!result_valid_q || result_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			it_q           <= '0;
			count_q        <= '0;
			pend_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) begin
				it_q   <= '0;
				pend_q <= 1'b0;
			end else begin
				if (step)
					it_q <= it_q + 1'b1;
				if (state_q == S_SQY)
					pend_q <= 1'b1;
			end
			if (finish)
				count_q <= fin_count;
			if (cmd.load_out)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	assign pixel_ready  = (state_q == S_IDLE);
	assign result_valid = result_valid_q;

endmodule

// ----- rtl/escape_time_fractal_pixel.sv -----
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel: Mandelbrot escape-time pixel in fixed point
// Maps a pixel to c = start + index * step (signed, 28 fraction bits),
// iterates z = z^2 + c and returns the escape count with a palette colour.
// ----------------------------------------------------------------------------
// One pixel word is taken at a time. After acceptance the block forms c in
// the states S_CX, S_CY and S_INIT, then runs each iteration through S_MUL,
// S_SQX and S_SQY (2xy, x*x, y*y all go through the single shared 34x34
// multiplier), makes the final escape test in S_MUL and loads the result
// register in S_DONE. The result word sits in its own register and is held
// until taken; the next pixel is accepted as soon as the previous result has
// moved into that register. Config registers may be written only while the
// block is idle.
module escape_time_fractal_pixel import etfp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]     cfg_data,
	input  logic                   pixel_valid,
	output logic                   pixel_ready,
	input  pixel_t                 pixel_data,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	etfp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	etfp_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_data  (pixel_data),
		.cmd         (cmd),
		.status      (status),
		.result_data (result_data)
	);

endmodule

// ----- rtl/etfp_checker.sv -----
// ----------------------------------------------------------------------------
// etfp_checker: port-level checks for the escape-time fractal pixel
// Watches the pixel and result channels of the top level.
// ----------------------------------------------------------------------------
module etfp_checker import etfp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   pixel_valid,
	input logic                   pixel_ready,
	input logic                   result_valid,
	input logic                   result_ready,
	input result_t                result_data
);

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result word changed while stalled");

	// one pixel in flight: no second word straight after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_ready |=> !pixel_ready)
		else $error("pixel accepted while another is in work");

	// points that never escape are black
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.iteration_count == COUNT_MAX |->
			result_data.red == '0 && result_data.green == '0 && result_data.blue == '0)
		else $error("non-escaping point not black");

	// every palette entry has some colour, so an escaped point is never black
	a_coloured: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.iteration_count != COUNT_MAX |->
			(result_data.red | result_data.green | result_data.blue) != '0)
		else $error("escaped point given black");

endmodule

bind escape_time_fractal_pixel etfp_checker u_checker (.*);

// ----- tb/escape_time_fractal_pixel_monitor.sv -----
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_monitor: bus watcher for the fractal pixel block
// Follows register writes, works out the escape count and colour of every
// accepted pixel word and checks each result word against the oldest one.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_monitor import etfp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]     cfg_data,
	input  logic                   pixel_valid,
	input  logic                   pixel_ready,
	input  pixel_t                 pixel_data,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  result_t                result_data,
	output int                     outstanding,
	output int                     mismatches,
	output int                     words_checked
);

	typedef logic signed [127:0] wide_t;

	localparam wide_t       COORD_HI     = 128'sd2147483647;
	localparam wide_t       COORD_LO     = -128'sd2147483648;
	localparam logic [127:0] PRODUCT_MAX = 128'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [127:0] MAG_CAP     = 128'd1 << 60;
	localparam wide_t       ESCAPE_BOUND = 128'sd4 <<< FRAC_BITS;

	logic signed [COORD_W-1:0] re_origin, re_pitch, im_origin, im_pitch;
	result_t expected_words[$];
	int backlog = 0;
	int errors  = 0;
	int checked = 0;

	assign outstanding   = backlog;
	assign mismatches    = errors;
	assign words_checked = checked;

	function automatic wide_t saturate_coord(input wide_t v);
		if (v > COORD_HI)
			return COORD_HI;
		if (v < COORD_LO)
			return COORD_LO;
		return v;
	endfunction

	// floor(a*b / 2^FRAC_BITS); a product beyond 64 bits, or a quotient past
	// 2^60, pins the magnitude at 2^60
	function automatic wide_t scaled_product(input wide_t a, input wide_t b);
		logic         neg;
		logic [127:0] ma, mb, prod, q;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? -a : a;
		mb  = (b < 0) ? -b : b;
		if (ma == 0 || mb == 0)
			return 0;
		prod = ma * mb;
		if (prod > PRODUCT_MAX) begin
			q = MAG_CAP;
		end else begin
			q = prod >> FRAC_BITS;
			if (neg && prod[FRAC_BITS-1:0] != 0)
				q = q + 1;
			if (q > MAG_CAP)
				q = MAG_CAP;
		end
		return neg ? -$signed(q) : $signed(q);
	endfunction

	function automatic colour_t shade(input logic [3:0] idx);
		colour_t c;
		case (idx)
			4'd0:  c = 24'h09012F;
			4'd1:  c = 24'h040449;
			4'd2:  c = 24'h000764;
			4'd3:  c = 24'h0C2C8A;
			4'd4:  c = 24'h1852B1;
			4'd5:  c = 24'h397DD1;
			4'd6:  c = 24'h86B5E5;
			4'd7:  c = 24'hD3ECF8;
			4'd8:  c = 24'hF1E9BF;
			4'd9:  c = 24'hF8C95F;
			4'd10: c = 24'hFFAA00;
			4'd11: c = 24'hCC8000;
			4'd12: c = 24'h995700;
			4'd13: c = 24'h6A3403;
			4'd14: c = 24'h421E0F;
			default: c = 24'h19071A;
		endcase
		return c;
	endfunction

	function automatic result_t escape_colour(input pixel_t p);
		wide_t   col_v, row_v, cx, cy, x, y, x2, y2;
		int      n;
		logic    escaped;
		colour_t c;
		result_t r;
		col_v = {118'd0, p.column};
		row_v = {119'd0, p.row};
		cx = saturate_coord(wide_t'(re_origin) + col_v * wide_t'(re_pitch));
		cy = saturate_coord(wide_t'(im_origin) + row_v * wide_t'(im_pitch));
		x = 0;
		y = 0;
		x2 = 0;
		y2 = 0;
		n = 0;
		escaped = 1'b0;
		while (!escaped && n < MAX_ITERATIONS) begin
			y  = scaled_product(x + x, y) + cy;
			x  = x2 - y2 + cx;
			x2 = scaled_product(x, x);
			y2 = scaled_product(y, y);
			if (x2 + y2 > ESCAPE_BOUND)
				escaped = 1'b1;
			else
				n++;
		end
		c = escaped ? shade(n[3:0]) : colour_t'(0);
		r.red = c.red;
		r.green = c.green;
		r.blue = c.blue;
		r.iteration_count = n[COUNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			re_origin <= '0;
			re_pitch  <= '0;
			im_origin <= '0;
			im_pitch  <= '0;
			expected_words.delete();
			backlog = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_X_START: re_origin <= cfg_data;
					REG_X_STEP:  re_pitch  <= cfg_data;
					REG_Y_START: im_origin <= cfg_data;
					REG_Y_STEP:  im_pitch  <= cfg_data;
					default: ;
				endcase
			end
			// result first, so a word can never be matched with its own pixel
			if (result_valid && result_ready) begin
				if (backlog == 0) begin
					$error("result word %h arrived with nothing expected", result_data);
					errors++;
				end else begin
					want = expected_words.pop_front();
					backlog--;
					check_field("red", want.red, result_data.red);
					check_field("green", want.green, result_data.green);
					check_field("blue", want.blue, result_data.blue);
					check_field("iteration_count", want.iteration_count,
						result_data.iteration_count);
					checked++;
				end
			end
			if (pixel_valid && pixel_ready) begin
				expected_words.push_back(escape_colour(pixel_data));
				backlog++;
			end
		end
	end

endmodule

// ----- tb/escape_time_fractal_pixel_test.sv -----
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_test: top-level bench for the fractal pixel block
// Drives register settings and pixel words with random gaps and stalls, one
// long result hold-off and full drains between settings; the monitor checks.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_test;
	import etfp_pkg::*;

	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 50;
	localparam int HOLD_CYCLES   = 3000;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 800;   // longer than one non-escaping pixel

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [COORD_W-1:0]     cfg_data;
	logic                   pixel_valid;
	logic                   pixel_ready;
	pixel_t                 pixel_data;
	logic                   result_valid;
	logic                   result_ready;
	result_t                result_data;

	int outstanding, mismatches, words_checked;
	int views = 0;
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_request = 1'b0;

	escape_time_fractal_pixel i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel_data   (pixel_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	escape_time_fractal_pixel_monitor i_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pixel_valid   (pixel_valid),
		.pixel_ready   (pixel_ready),
		.pixel_data    (pixel_data),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result_data   (result_data),
		.outstanding   (outstanding),
		.mismatches    (mismatches),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("** escape_time_fractal_pixel: FAILED **");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int k;
		result_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_ready <= 1'b1;
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				k = $urandom_range(1, 4);
				result_ready <= 1'b0;
				repeat (k) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	task automatic offer_pixel(input logic [COLUMN_W-1:0] col, input logic [ROW_W-1:0] row);
		int gap;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_data  <= {col, row};
		do @(posedge clk); while (!pixel_ready);
	endtask

	task automatic offer_random_pixel();
		logic [COLUMN_W-1:0] col;
		logic [ROW_W-1:0]    row;
		// mostly on screen, now and then anywhere the fields reach
		if ($urandom_range(0, 7) == 0) begin
			col = COLUMN_W'($urandom_range(0, 1023));
			row = ROW_W'($urandom_range(0, 511));
		end else begin
			col = COLUMN_W'($urandom_range(0, 639));
			row = ROW_W'($urandom_range(0, 479));
		end
		offer_pixel(col, row);
	endtask

	// wait until every pixel word has come back, then a little longer
	task automatic settle();
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_view(input logic [31:0] xs, input logic [31:0] xd,
			input logic [31:0] ys, input logic [31:0] yd);
		cfg_write <= 1'b1;
		cfg_index <= REG_X_START;
		cfg_data  <= xs;
		@(posedge clk);
		cfg_index <= REG_X_STEP;
		cfg_data  <= xd;
		@(posedge clk);
		cfg_index <= REG_Y_START;
		cfg_data  <= ys;
		@(posedge clk);
		cfg_index <= REG_Y_STEP;
		cfg_data  <= yd;
		@(posedge clk);
		cfg_write <= 1'b0;
		views++;
	endtask

	// a window somewhere over the set, zoomed in by a random amount
	task automatic zoom_view();
		logic [31:0] xs, xd, ys, yd;
		int          zoom;
		zoom = $urandom_range(0, 6);
		xs = -32'sd671088640 + $urandom_range(0, 671088640);
		ys = -32'sd335544320 + $urandom_range(0, 671088640);
		xd = $urandom_range(0, 1468006) >> zoom;
		yd = $urandom_range(0, 1398101) >> zoom;
		if ($urandom_range(0, 3) == 0)
			xd = -xd;
		if ($urandom_range(0, 3) == 0)
			yd = -yd;
		set_view(xs, xd, ys, yd);
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_write   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		pixel_valid = 1'b0;
		pixel_data  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: c is zero everywhere and never escapes
		offer_pixel(10'd0, 9'd0);
		offer_pixel(10'd1023, 9'd511);
		pixel_valid <= 1'b0;
		settle();

		// full view of the set, corners, off-image indexes and the neck
		set_view(-32'sd671088640, 32'sd1468006, -32'sd335544320, 32'sd1398101);
		offer_pixel(10'd0, 9'd0);
		offer_pixel(10'd639, 9'd479);
		offer_pixel(10'd1023, 9'd511);
		offer_pixel(10'd0, 9'd511);
		offer_pixel(10'd1023, 9'd0);
		offer_pixel(10'd457, 9'd240);
		offer_pixel(10'd320, 9'd240);
		pixel_valid <= 1'b0;
		settle();

		// coordinates pushed past the register range in both directions
		set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		offer_pixel(10'd0, 9'd0);
		offer_pixel(10'd1, 9'd1);
		offer_pixel(10'd1023, 9'd511);
		offer_pixel(10'd512, 9'd256);
		pixel_valid <= 1'b0;
		settle();

		// c = -2 exactly: sits on the boundary and never escapes
		set_view(-32'sd536870912, 32'd0, 32'd0, 32'd0);
		offer_pixel(10'd5, 9'd7);
		pixel_valid <= 1'b0;
		settle();

		// cusp at 0.25 and a mirrored view with negative steps
		set_view(32'sd67108864, -32'sd1468006, 32'sd335544320, -32'sd1398101);
		offer_pixel(10'd0, 9'd240);
		offer_pixel(10'd300, 9'd100);
		offer_pixel(10'd639, 9'd479);
		pixel_valid <= 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph == 0)
				set_view($urandom, $urandom, $urandom, $urandom);
			else
				zoom_view();
			tx_gaps = (ph != PHASES - 1);
			rx_gaps = (ph != PHASES - 1);
			// stall the result side long enough for the input to back up
			if (ph == 2)
				hold_request = 1'b1;
			repeat (PHASE_ITEMS) offer_random_pixel();
			pixel_valid <= 1'b0;
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d pixel words checked over %0d register settings: reset, full view,",
			words_checked, views);
		$display("saturated, boundary, mirrored, random and zoomed windows");
		if (mismatches == 0 && outstanding == 0)
			$display("** escape_time_fractal_pixel: PASSED **");
		else
			$display("** escape_time_fractal_pixel: FAILED **");
		$finish;
	end

endmodule
